/* design/i2c_master_byte_controller_unit_assert.svh */
// assertion macros for the i2c master byte controller checker
`ifndef I2C_MASTER_BYTE_CONTROLLER_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/i2cm_pkg.sv */
// shared types and constants of the i2c master byte controller
`default_nettype none

package i2cm_pkg;

	localparam int unsigned TPU_W = 10;
	localparam int unsigned TMO_W = 8;
	localparam int unsigned CFG_W = 10;
	localparam int unsigned DLY_W = 12;

	localparam logic [TPU_W-1:0] TPU_RESET = 10'd100;
	localparam logic [TMO_W-1:0] TMO_RESET = 8'd250;

	localparam logic CFG_TICKS_PER_US = 1'b0;
	localparam logic CFG_ACK_TIMEOUT  = 1'b1;

	localparam logic [2:0] MODE_NONE     = 3'd0;
	localparam logic [2:0] MODE_START    = 3'd1;
	localparam logic [2:0] MODE_STOP     = 3'd2;
	localparam logic [2:0] MODE_WRITE    = 3'd3;
	localparam logic [2:0] MODE_READ_ACK = 3'd4;
	localparam logic [2:0] MODE_READ_NAK = 3'd5;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       ready_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_error;
	} res_t;

endpackage

`default_nettype wire

/* design/i2cm_core.sv */
// bus sequencer state and per-tick next-state logic
`default_nettype none

module i2cm_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [i2cm_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                     take,
	input  wire logic [2:0]               mode,
	input  wire logic [7:0]               write_data,
	input  wire logic                     sda_in,
	output i2cm_pkg::res_t                res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_STA_A, PH_STA_B, PH_STP_A, PH_STP_B, PH_WR_LO, PH_WR_HI,
		PH_ACK_REL, PH_ACK_HI, PH_ACK_POLL, PH_RD_LO, PH_RD_HI, PH_ANS_LO, PH_ANS_HI
	} phase_t;

	logic [i2cm_pkg::TPU_W-1:0] tpu_q;
	logic [i2cm_pkg::TMO_W-1:0] tmo_q;
	phase_t                     phase_q;
	logic [i2cm_pkg::DLY_W-1:0] delay_q;
	logic [3:0]                 bit_q;
	logic [7:0]                 shift_q;
	logic [7:0]                 wait_q;
	logic                       scl_q;
	logic                       sda_q;
	logic                       err_q;
	logic                       drive_q;
	logic [7:0]                 rx_q;
	logic                       nack_q;

	phase_t                     n_phase;
	phase_t                     ent;
	logic                       do_enter;
	logic [i2cm_pkg::DLY_W-1:0] n_delay;
	logic [i2cm_pkg::DLY_W-1:0] dly;
	logic [2:0]                 us;
	logic [3:0]                 n_bit;
	logic [7:0]                 n_shift;
	logic [7:0]                 n_wait;
	logic                       n_scl;
	logic                       n_sda;
	logic                       n_err;
	logic                       n_drive;
	logic [7:0]                 n_rx;
	logic                       n_nack;
	logic                       done;

	always_comb begin
		n_phase  = phase_q;
		n_delay  = delay_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_wait   = wait_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_err    = err_q;
		n_drive  = drive_q;
		n_rx     = rx_q;
		n_nack   = nack_q;
		done     = 1'b0;
		do_enter = 1'b0;
		ent      = PH_IDLE;
		us       = 3'd0;
		dly      = '0;

		if (phase_q == PH_IDLE) begin
			case (mode)
				i2cm_pkg::MODE_START: begin
					do_enter = 1'b1;
					ent      = PH_STA_A;
				end
				i2cm_pkg::MODE_STOP: begin
					do_enter = 1'b1;
					ent      = PH_STP_A;
				end
				i2cm_pkg::MODE_WRITE: begin
					n_shift  = write_data;
					n_bit    = 4'd0;
					do_enter = 1'b1;
					ent      = PH_WR_LO;
				end
				i2cm_pkg::MODE_READ_ACK, i2cm_pkg::MODE_READ_NAK: begin
					n_nack   = (mode == i2cm_pkg::MODE_READ_NAK);
					n_shift  = 8'd0;
					n_bit    = 4'd0;
					do_enter = 1'b1;
					ent      = PH_RD_LO;
				end
				default: begin
				end
			endcase
		end else if (phase_q == PH_ACK_POLL) begin
			if (!sda_in) begin
				n_scl   = 1'b0;
				n_err   = 1'b0;
				n_phase = PH_IDLE;
				done    = 1'b1;
			end else if (wait_q >= tmo_q) begin
				n_err    = 1'b1;
				do_enter = 1'b1;
				ent      = PH_STP_A;
			end else begin
				n_wait = wait_q + 8'd1;
			end
		end else if (delay_q != '0) begin
			n_delay = delay_q - 1'b1;
		end else begin
			case (phase_q)
				PH_STA_A: begin
					do_enter = 1'b1;
					ent      = PH_STA_B;
				end
				PH_STA_B: begin
					n_scl   = 1'b0;
					n_phase = PH_IDLE;
					done    = 1'b1;
				end
				PH_STP_A: begin
					do_enter = 1'b1;
					ent      = PH_STP_B;
				end
				PH_STP_B: begin
					n_phase = PH_IDLE;
					done    = 1'b1;
				end
				PH_WR_LO: begin
					do_enter = 1'b1;
					ent      = PH_WR_HI;
				end
				PH_WR_HI: begin
					n_scl    = 1'b0;
					n_shift  = {shift_q[6:0], 1'b0};
					n_bit    = bit_q + 4'd1;
					do_enter = 1'b1;
					ent      = (n_bit < 4'd8) ? PH_WR_LO : PH_ACK_REL;
				end
				PH_ACK_REL: begin
					do_enter = 1'b1;
					ent      = PH_ACK_HI;
				end
				PH_ACK_HI: begin
					do_enter = 1'b1;
					ent      = PH_ACK_POLL;
				end
				PH_RD_LO: begin
					do_enter = 1'b1;
					ent      = PH_RD_HI;
				end
				PH_RD_HI: begin
					n_bit    = bit_q + 4'd1;
					do_enter = 1'b1;
					if (n_bit < 4'd8) begin
						ent = PH_RD_LO;
					end else begin
						n_rx = shift_q;
						ent  = PH_ANS_LO;
					end
				end
				PH_ANS_LO: begin
					do_enter = 1'b1;
					ent      = PH_ANS_HI;
				end
				PH_ANS_HI: begin
					n_scl   = 1'b0;
					n_phase = PH_IDLE;
					done    = 1'b1;
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		if (do_enter) begin
			n_phase = ent;
			case (ent)
				PH_STA_A: begin
					n_drive = 1'b1;
					n_sda   = 1'b1;
					n_scl   = 1'b1;
					us      = 3'd4;
				end
				PH_STA_B: begin
					n_sda = 1'b0;
					us    = 3'd4;
				end
				PH_STP_A: begin
					n_drive = 1'b1;
					n_scl   = 1'b0;
					n_sda   = 1'b0;
					us      = 3'd4;
				end
				PH_STP_B: begin
					n_scl = 1'b1;
					n_sda = 1'b1;
					us    = 3'd4;
				end
				PH_WR_LO: begin
					n_drive = 1'b1;
					n_scl   = 1'b0;
					n_sda   = n_shift[7];
					us      = 3'd2;
				end
				PH_WR_HI: begin
					n_scl = 1'b1;
					us    = 3'd2;
				end
				PH_ACK_REL: begin
					n_drive = 1'b0;
					n_sda   = 1'b1;
					us      = 3'd1;
				end
				PH_ACK_HI: begin
					n_scl = 1'b1;
					us    = 3'd1;
				end
				PH_ACK_POLL: begin
					n_wait = 8'd0;
				end
				PH_RD_LO: begin
					n_drive = 1'b0;
					n_sda   = 1'b1;
					n_scl   = 1'b0;
					us      = 3'd2;
				end
				PH_RD_HI: begin
					n_scl   = 1'b1;
					n_shift = {n_shift[6:0], sda_in};
					us      = 3'd1;
				end
				PH_ANS_LO: begin
					n_scl   = 1'b0;
					n_drive = 1'b1;
					n_sda   = n_nack;
					us      = 3'd2;
				end
				PH_ANS_HI: begin
					n_scl = 1'b1;
					us    = 3'd2;
				end
				default: begin
				end
			endcase
			// segment length in ticks is us scaled by ticks_per_us
			case (us)
				3'd1:    dly = {2'b00, tpu_q};
				3'd2:    dly = {1'b0, tpu_q, 1'b0};
				3'd4:    dly = {tpu_q, 2'b00};
				default: dly = '0;
			endcase
			n_delay = (dly == '0) ? '0 : dly - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q   <= i2cm_pkg::TPU_RESET;
			tmo_q   <= i2cm_pkg::TMO_RESET;
			phase_q <= PH_IDLE;
			delay_q <= '0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			wait_q  <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			err_q   <= 1'b0;
			drive_q <= 1'b1;
			rx_q    <= 8'd0;
			nack_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					i2cm_pkg::CFG_TICKS_PER_US: tpu_q <= cfg_data[i2cm_pkg::TPU_W-1:0];
					i2cm_pkg::CFG_ACK_TIMEOUT:  tmo_q <= cfg_data[i2cm_pkg::TMO_W-1:0];
					default: begin
					end
				endcase
			end
			if (take) begin
				phase_q <= n_phase;
				delay_q <= n_delay;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				wait_q  <= n_wait;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				err_q   <= n_err;
				drive_q <= n_drive;
				rx_q    <= n_rx;
				nack_q  <= n_nack;
			end
		end
	end

	always_comb begin
		res.scl       = n_scl;
		res.sda_out   = n_drive ? n_sda : 1'b1;
		res.sda_drive = n_drive;
		res.ready_res = (n_phase == PH_IDLE);
		res.done_res  = done;
		res.read_data = n_rx;
		res.ack_error = n_err;
	end

endmodule

`default_nettype wire

/* design/i2cm_out_reg.sv */
// output word register with valid/stall handshake
`default_nettype none

module i2cm_out_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                take,
	input  i2cm_pkg::res_t      res,
	output logic                out_valid,
	input  wire logic           out_stall,
	output i2cm_pkg::res_t      res_q
);

	logic out_valid_q;

	assign in_stall  = out_valid_q & out_stall;
	assign take      = in_valid & ~in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

/* design/i2c_master_byte_controller_unit.sv */
// latency: a result word is registered at the edge that accepts its input word
// and is offered on the output the cycle after
// throughput: one input word per cycle while the output is not stalled, one result word per input word
// reset: sequencer idle, scl and sda high and driven, timing registers 100 and 250
// the output register holds one word and takes a new one while the old one leaves
`default_nettype none

module i2c_master_byte_controller_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [i2cm_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [2:0]                 mode,
	input  wire logic [7:0]                 write_data,
	input  wire logic                       sda_in,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            scl,
	output logic                            sda_out,
	output logic                            sda_drive,
	output logic                            ready_res,
	output logic                            done_res,
	output logic [7:0]                      read_data,
	output logic                            ack_error
);

	logic           take;
	i2cm_pkg::res_t res;
	i2cm_pkg::res_t res_q;

	i2cm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.take       (take),
		.mode       (mode),
		.write_data (write_data),
		.sda_in     (sda_in),
		.res        (res)
	);

	i2cm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.take      (take),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign scl       = res_q.scl;
	assign sda_out   = res_q.sda_out;
	assign sda_drive = res_q.sda_drive;
	assign ready_res = res_q.ready_res;
	assign done_res  = res_q.done_res;
	assign read_data = res_q.read_data;
	assign ack_error = res_q.ack_error;

endmodule

`default_nettype wire

/* design/i2cm_checker.sv */
// port-level checker for the i2c master byte controller and its bind
`default_nettype none

`include "i2c_master_byte_controller_unit_assert.svh"

module i2cm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic sda_out,
	input wire logic sda_drive,
	input wire logic ready_res,
	input wire logic done_res
);

	`I2CM_ASSERT_NOW(a_stall_needs_full, clk, arst_n, in_stall, out_valid, "input stalled with empty output")
	`I2CM_ASSERT_NOW(a_done_is_idle, clk, arst_n, out_valid && done_res, ready_res, "done word not idle")
	`I2CM_ASSERT_NOW(a_released_high, clk, arst_n, out_valid && !sda_drive, sda_out, "released sda not high")
	`I2CM_ASSERT_NEXT(a_word_held, clk, arst_n, out_valid && out_stall, out_valid, "stalled word dropped")

endmodule

bind i2c_master_byte_controller_unit i2cm_checker u_i2cm_checker (.*);

`default_nettype wire
